// ===== rtl/tsas_pkg.sv =====
`default_nettype none

package tsas_pkg;

	localparam int RAW_W      = 16;
	localparam int POS_W      = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	// dividend width of the shared divider: a raw difference times a screen span
	localparam int DIV_W      = RAW_W + POS_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic [RAW_W-1:0] RST_RAW_X_MIN     = 16'd1500;
	localparam logic [RAW_W-1:0] RST_RAW_X_MAX     = 16'd31000;
	localparam logic [RAW_W-1:0] RST_RAW_Y_MIN     = 16'd3276;
	localparam logic [RAW_W-1:0] RST_RAW_Y_MAX     = 16'd30110;
	localparam logic [POS_W-1:0] RST_SCREEN_WIDTH  = 12'd240;
	localparam logic [POS_W-1:0] RST_SCREEN_HEIGHT = 12'd320;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAW_X_MIN     = 3'd0,
		REG_RAW_X_MAX     = 3'd1,
		REG_RAW_Y_MIN     = 3'd2,
		REG_RAW_Y_MAX     = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_x_min;
		logic [RAW_W-1:0] raw_x_max;
		logic [RAW_W-1:0] raw_y_min;
		logic [RAW_W-1:0] raw_y_max;
		logic [POS_W-1:0] screen_width;
		logic [POS_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [RAW_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AVG,
		S_CLAMP,
		S_MUL,
		S_SCL,
		S_SCL_W,
		S_EMIT
	} seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/tsas_in_if.sv =====
`default_nettype none

interface tsas_in_if import tsas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pen_down;
	logic [RAW_W-1:0] raw_x_word;
	logic [RAW_W-1:0] raw_y_word;

	modport source (output valid, output pen_down, output raw_x_word, output raw_y_word,
		input ready);
	modport sink (input valid, input pen_down, input raw_x_word, input raw_y_word,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/tsas_out_if.sv =====
`default_nettype none

interface tsas_out_if import tsas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             touched;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;

	modport source (output valid, output touched, output pos_x, output pos_y, input ready);
	modport sink (input valid, input touched, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsas_cfg.sv =====
`default_nettype none

module tsas_cfg import tsas_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_x_min     <= RST_RAW_X_MIN;
			cfg_q.raw_x_max     <= RST_RAW_X_MAX;
			cfg_q.raw_y_min     <= RST_RAW_Y_MIN;
			cfg_q.raw_y_max     <= RST_RAW_Y_MAX;
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
		end else if (cfg_wr_en) begin
			// drop writes to unmapped indexes
			case (cfg_index)
				REG_RAW_X_MIN:     cfg_q.raw_x_min     <= cfg_data[RAW_W-1:0];
				REG_RAW_X_MAX:     cfg_q.raw_x_max     <= cfg_data[RAW_W-1:0];
				REG_RAW_Y_MIN:     cfg_q.raw_y_min     <= cfg_data[RAW_W-1:0];
				REG_RAW_Y_MAX:     cfg_q.raw_y_max     <= cfg_data[RAW_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[POS_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tsas_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tsas_div import tsas_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_req_t  req,
	output div_rsp_t  rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RAW_W-1:0]     rem_q;
	logic [RAW_W-1:0]     dsr_q;
	logic [DIV_W-1:0]     quo_q;

	logic [RAW_W:0]       trial;
	logic                 fits;
	logic                 last;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		last  = cnt_q == DIV_CNT_W'(DIV_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? RAW_W'(trial - {1'b0, dsr_q}) : trial[RAW_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/touch_sample_average_scale.sv =====
// A pen-down item that is not the last of its group is only added to the sums and gives no result.
// A pen-up item goes to the emit state, which loads the output register once it is free.
// The last pen-down item of a group passes average, clamp and multiply for each axis, and the shared
// 28-step divider runs once per axis for the scaling, unless that axis's raw window is empty.
// One item at a time; input ready returns once the result sits in the output register.
// Reset (arst_n low, asynchronous): counts and sums clear, registers take default limits.
`default_nettype none

module touch_sample_average_scale import tsas_pkg::*; #(
	parameter int SAMPLES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tsas_in_if.sink                    sample,
	tsas_out_if.source                 result
);

	localparam int SUM_W  = RAW_W + $clog2(SAMPLES);
	localparam int CNT_W  = $clog2(SAMPLES);
	// average by reciprocal multiplication, exact for every sum of SUM_W bits
	localparam int AVG_SH = SUM_W + CNT_W;
	localparam logic [SUM_W:0] AVG_M =
		(SUM_W+1)'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

	cfg_t       cfg;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	seq_state_t state_q, state_d;

	logic             axis_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;
	logic [RAW_W-1:0] avg_q;
	logic [RAW_W-1:0] diff_q;
	logic [RAW_W-1:0] den_q;
	logic             empty_q;
	logic [DIV_W-1:0] prod_q;
	logic             touched_q;
	logic [POS_W-1:0] pos_x_q;
	logic [POS_W-1:0] pos_y_q;
	logic             out_valid_q;
	logic             out_touched_q;
	logic [POS_W-1:0] out_x_q;
	logic [POS_W-1:0] out_y_q;

	logic             accept;
	logic             last_sample;
	logic             out_free;
	logic [RAW_W-1:0] lo;
	logic [RAW_W-1:0] hi;
	logic [POS_W-1:0] span;
	logic [RAW_W-1:0] avg_lo;
	logic [RAW_W-1:0] avg_clamped;
	logic [SUM_W-1:0] avg_sum;
	logic [2*SUM_W:0] avg_prod;
	logic [RAW_W-1:0] avg_calc;

	tsas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		accept      = sample.valid && sample.ready;
		last_sample = count_q == CNT_W'(SAMPLES - 1);
		out_free    = !out_valid_q || result.ready;
		lo          = axis_q ? cfg.raw_y_min : cfg.raw_x_min;
		hi          = axis_q ? cfg.raw_y_max : cfg.raw_x_max;
		span        = axis_q ? cfg.screen_height : cfg.screen_width;
		avg_sum     = axis_q ? sum_y_q : sum_x_q;
		avg_prod    = (2*SUM_W+1)'(avg_sum) * (2*SUM_W+1)'(AVG_M);
		avg_calc    = RAW_W'(avg_prod >> AVG_SH);
		// clamp to min first, then to max
		avg_lo      = (avg_q < lo) ? lo : avg_q;
		avg_clamped = (avg_lo > hi) ? hi : avg_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		sample.ready     = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = den_q;
		unique case (state_q)
			S_IDLE: begin
				sample.ready = 1'b1;
				if (accept) begin
					if (!sample.pen_down)
						state_d = S_EMIT;
					else if (last_sample)
						state_d = S_AVG;
				end
			end
			S_AVG: state_d = S_CLAMP;
			S_CLAMP: state_d = S_MUL;
			S_MUL: begin
				if (!empty_q)
					state_d = S_SCL;
				else
					state_d = axis_q ? S_EMIT : S_AVG;
			end
			S_SCL: begin
				div_req.start = 1'b1;
				state_d       = S_SCL_W;
			end
			S_SCL_W: begin
				if (div_rsp.done)
					state_d = axis_q ? S_EMIT : S_AVG;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state: count, sums, axis select, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!sample.pen_down) begin
					count_q <= '0;
					sum_x_q <= '0;
					sum_y_q <= '0;
				end else begin
					count_q <= last_sample ? '0 : count_q + 1'b1;
					sum_x_q <= sum_x_q + SUM_W'(sample.raw_x_word);
					sum_y_q <= sum_y_q + SUM_W'(sample.raw_y_word);
				end
			end
			// advance to the Y axis once X is done, and back to X once Y is done
			if ((state_q == S_MUL && empty_q) || (state_q == S_SCL_W && div_rsp.done))
				axis_q <= !axis_q;
			if (state_q == S_EMIT && out_free) begin
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			touched_q <= sample.pen_down;
			if (!sample.pen_down) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
			end
		end
		if (state_q == S_AVG)
			avg_q <= avg_calc;
		if (state_q == S_CLAMP) begin
			diff_q  <= avg_clamped - lo;
			den_q   <= hi - lo;
			empty_q <= hi <= lo;
		end
		if (state_q == S_MUL) begin
			prod_q <= DIV_W'(diff_q) * DIV_W'(span);
			if (empty_q) begin
				if (axis_q)
					pos_y_q <= '0;
				else
					pos_x_q <= '0;
			end
		end
		if (state_q == S_SCL_W && div_rsp.done) begin
			if (axis_q)
				pos_y_q <= div_rsp.quotient[POS_W-1:0];
			else
				pos_x_q <= div_rsp.quotient[POS_W-1:0];
		end
		if (state_q == S_EMIT && out_free) begin
			out_touched_q <= touched_q;
			out_x_q       <= pos_x_q;
			out_y_q       <= pos_y_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.touched = out_touched_q;
	assign result.pos_x   = out_x_q;
	assign result.pos_y   = out_y_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_penup_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !sample.pen_down) |=> state_q == S_EMIT)
		else $error("pen-up transaction did not go to emit");

	a_release_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_touched_q) |-> (out_x_q == '0 && out_y_q == '0))
		else $error("released result carries a nonzero position");

	a_x_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_touched_q) |-> out_x_q <= cfg.screen_width)
		else $error("X position exceeds screen width");

endmodule

`default_nettype wire

// ===== sim/tsas_report_checker.sv =====
`default_nettype none

module tsas_report_checker import tsas_pkg::*; #(
	parameter int SAMPLES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	tsas_in_if                         sample,
	tsas_out_if                        result,
	output int                         fail_count,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W = RAW_W + $clog2(SAMPLES);

	typedef struct {
		logic             touched;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} touch_report_t;

	cfg_t             limits;
	int               taken;
	logic [SUM_W-1:0] acc_x;
	logic [SUM_W-1:0] acc_y;
	touch_report_t    expected_reports[$];
	touch_report_t    want;

	// Average, clamp to the raw window, then stretch the window onto the screen span.
	function automatic logic [POS_W-1:0] map_axis(input logic [SUM_W-1:0] sum,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
			input logic [POS_W-1:0] span);
		logic [RAW_W-1:0] avg;
		logic [31:0]      prod;
		avg = RAW_W'(sum / SUM_W'(SAMPLES));
		if (avg < lo) avg = lo;
		if (avg > hi) avg = hi;
		if (hi <= lo) return '0;
		prod = 32'(avg - lo) * 32'(span);
		return POS_W'(prod / 32'(hi - lo));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits.raw_x_min     = RST_RAW_X_MIN;
			limits.raw_x_max     = RST_RAW_X_MAX;
			limits.raw_y_min     = RST_RAW_Y_MIN;
			limits.raw_y_max     = RST_RAW_Y_MAX;
			limits.screen_width  = RST_SCREEN_WIDTH;
			limits.screen_height = RST_SCREEN_HEIGHT;
			taken = 0;
			acc_x = '0;
			acc_y = '0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_RAW_X_MIN:     limits.raw_x_min = cfg_data;
					REG_RAW_X_MAX:     limits.raw_x_max = cfg_data;
					REG_RAW_Y_MIN:     limits.raw_y_min = cfg_data;
					REG_RAW_Y_MAX:     limits.raw_y_max = cfg_data;
					REG_SCREEN_WIDTH:  limits.screen_width = cfg_data[POS_W-1:0];
					REG_SCREEN_HEIGHT: limits.screen_height = cfg_data[POS_W-1:0];
					default: ;
				endcase
			end

			// check the outgoing transaction before adding any new expectation
			if (result.valid && result.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report touched=%0d pos_x=%0d pos_y=%0d",
						$time, result.touched, result.pos_x, result.pos_y);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (result.touched !== want.touched) begin
						$display("%0t: touched expected %0d actual %0d",
							$time, want.touched, result.touched);
						fail_count++;
					end
					if (result.pos_x !== want.pos_x) begin
						$display("%0t: pos_x expected %0d actual %0d",
							$time, want.pos_x, result.pos_x);
						fail_count++;
					end
					if (result.pos_y !== want.pos_y) begin
						$display("%0t: pos_y expected %0d actual %0d",
							$time, want.pos_y, result.pos_y);
						fail_count++;
					end
				end
			end

			if (sample.valid && sample.ready) begin
				if (!sample.pen_down) begin
					// pen lifted: drop the partial average
					taken = 0;
					acc_x = '0;
					acc_y = '0;
					want.touched = 1'b0;
					want.pos_x = '0;
					want.pos_y = '0;
					expected_reports.push_back(want);
				end else begin
					acc_x = acc_x + SUM_W'(sample.raw_x_word);
					acc_y = acc_y + SUM_W'(sample.raw_y_word);
					taken++;
					if (taken == SAMPLES) begin
						want.touched = 1'b1;
						want.pos_x = map_axis(acc_x, limits.raw_x_min, limits.raw_x_max,
							limits.screen_width);
						want.pos_y = map_axis(acc_y, limits.raw_y_min, limits.raw_y_max,
							limits.screen_height);
						expected_reports.push_back(want);
						taken = 0;
						acc_x = '0;
						acc_y = '0;
					end
				end
			end
			pending = expected_reports.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_touch_sample_average_scale.sv =====
`default_nettype none

module tb_touch_sample_average_scale;
	timeunit 1ns;
	timeprecision 1ps;
	import tsas_pkg::*;

	localparam int SAMPLES     = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 170;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  idle_on;
	int                    fail_count;
	int                    pending;
	int                    cycle_count = 0;

	tsas_in_if  sample_if();
	tsas_out_if result_if();

	touch_sample_average_scale #(.SAMPLES(SAMPLES)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if),
		.result    (result_if)
	);

	tsas_report_checker #(.SAMPLES(SAMPLES)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample_if),
		.result     (result_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: stall at random unless idling is switched off
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready = idle_on ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_limits(input logic [RAW_W-1:0] x_lo, input logic [RAW_W-1:0] x_hi,
			input logic [RAW_W-1:0] y_lo, input logic [RAW_W-1:0] y_hi,
			input logic [POS_W-1:0] width, input logic [POS_W-1:0] height);
		write_reg(REG_RAW_X_MIN, x_lo);
		write_reg(REG_RAW_X_MAX, x_hi);
		write_reg(REG_RAW_Y_MIN, y_lo);
		write_reg(REG_RAW_Y_MAX, y_hi);
		write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(width));
		write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(height));
	endtask

	// call at a falling edge; returns at the falling edge after the transaction
	task automatic send_sample(input logic pen, input logic [RAW_W-1:0] x,
			input logic [RAW_W-1:0] y);
		while (idle_on && $urandom_range(99) < 30) begin
			sample_if.valid = 1'b0;
			@(negedge clk);
		end
		sample_if.valid      = 1'b1;
		sample_if.pen_down   = pen;
		sample_if.raw_x_word = x;
		sample_if.raw_y_word = y;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		@(negedge clk);
		sample_if.valid = 1'b0;
	endtask

	// hold until every report has come out and the block has gone quiet
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [RAW_W-1:0] pick_word(input int center, input int spread);
		int mode;
		int v;
		mode = $urandom_range(99);
		if (mode < 10) return RAW_W'($urandom());
		if (mode < 15) return ($urandom_range(1) != 0) ? '1 : '0;
		v = center + $urandom_range(2 * spread) - spread;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return RAW_W'(v);
	endfunction

	task automatic run_touches(input int budget);
		int sent;
		int kind;
		int len;
		int cx;
		int cy;
		int spread;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(99);
			if (kind < 90) begin
				// a touch: a full group, or a short one broken off by a pen-up
				len = (kind < 75) ? SAMPLES : $urandom_range(SAMPLES - 1, 1);
				cx = $urandom_range(65535);
				cy = $urandom_range(65535);
				spread = $urandom_range(2047);
				for (int i = 0; i < len; i++)
					send_sample(1'b1, pick_word(cx, spread), pick_word(cy, spread));
				sent += len;
				if (len < SAMPLES) begin
					send_sample(1'b0, RAW_W'($urandom()), RAW_W'($urandom()));
					sent++;
				end
			end else begin
				send_sample(1'b0, RAW_W'($urandom()), RAW_W'($urandom()));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = REG_RAW_X_MIN;
		cfg_data             = '0;
		idle_on              = 1'b1;
		sample_if.valid      = 1'b0;
		sample_if.pen_down   = 1'b0;
		sample_if.raw_x_word = '0;
		sample_if.raw_y_word = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset limits: pen-up with nothing taken, words at the top, a broken touch
		send_sample(1'b0, '1, '1);
		for (int i = 0; i < SAMPLES; i++) send_sample(1'b1, '1, '1);
		for (int i = 0; i < 3; i++) send_sample(1'b1, '0, '0);
		send_sample(1'b0, '0, '0);
		run_touches(PHASE_ITEMS);
		settle();

		// widest windows and spans
		set_limits('0, '1, '0, '1, '1, '1);
		run_touches(PHASE_ITEMS);
		settle();

		// X limits crossed, Y window empty
		set_limits(16'd40000, 16'd1000, 16'd30000, 16'd30000, 12'd100, 12'd200);
		run_touches(PHASE_ITEMS);
		settle();

		// spans of zero and one
		set_limits(16'd1000, 16'd60000, 16'd500, 16'd20000, 12'd0, 12'd1);
		run_touches(PHASE_ITEMS);
		settle();

		// narrow windows, back-to-back traffic with no stalls
		idle_on = 1'b0;
		set_limits(16'd30000, 16'd30001, 16'd0, 16'd1, '1, '1);
		run_touches(PHASE_ITEMS);
		settle();
		idle_on = 1'b1;

		for (int p = 0; p < 4; p++) begin
			set_limits(RAW_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()),
				RAW_W'($urandom()), POS_W'($urandom()), POS_W'($urandom()));
			run_touches(PHASE_ITEMS);
			settle();
		end

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
